// ===== sv/ect_pkg.sv =====
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types, constants and index helpers for the ear-clipping triangulator.
// ----------------------------------------------------------------------------
package ect_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int AW           = $clog2(MAX_VERTICES);
    localparam int NW           = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W        = 2 * COORD_BITS + 4;
    localparam int ACC_W        = SUM_W + AW;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_NOEAR = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_vtx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         last_vertex;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] corner_a_x;
        logic signed [COORD_BITS-1:0] corner_a_y;
        logic signed [COORD_BITS-1:0] corner_b_x;
        logic signed [COORD_BITS-1:0] corner_b_y;
        logic signed [COORD_BITS-1:0] corner_c_x;
        logic signed [COORD_BITS-1:0] corner_c_y;
        logic                         has_triangle;
        logic                         final_result;
        logic [1:0]                   status;
    } t_out;

    typedef struct packed {
        logic start;
        t_vtx a;
        t_vtx b;
        t_vtx c;
    } t_sign_req;

    typedef enum logic [2:0] {
        SS_ABC,
        SS_ABP,
        SS_BCP,
        SS_CAP,
        SS_FAN
    } t_ssel;

    typedef enum logic [5:0] {
        S_IDLE, S_START, S_ROUND, S_FIN,
        S_AR0, S_AR1, S_AR2, S_AR3, S_AR4, S_ARD,
        S_RV0, S_RV1, S_RV2, S_RV3,
        S_CL0, S_CL1, S_CL2, S_CL3,
        S_ES0, S_ES1, S_ES2,
        S_EI0, S_EI1, S_EI2, S_EI3, S_EI4, S_EI5,
        S_CUT0, S_CUT1, S_CUT2, S_CUT3, S_CUT4, S_CUT5, S_CUT6, S_CUT8, S_CUT9,
        S_F0, S_F1, S_F2, S_F3,
        S_SG0, S_SG1,
        S_E0, S_E1,
        S_EMIT, S_DONE
    } t_state;

    function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i,
                                               input logic [NW-1:0] n);
        logic [NW-1:0] m;
        m = n - NW'(1);
        return (i == '0) ? m[AW-1:0] : i - AW'(1);
    endfunction

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i,
                                               input logic [NW-1:0] n);
        logic [NW-1:0] s;
        s = NW'(i) + NW'(1);
        return (s >= n) ? '0 : s[AW-1:0];
    endfunction

    function automatic t_out mk_out(input t_vtx a, input t_vtx b, input t_vtx c,
                                    input logic has, input logic fin,
                                    input logic [1:0] st);
        t_out o;
        o.corner_a_x   = has ? a.x : '0;
        o.corner_a_y   = has ? a.y : '0;
        o.corner_b_x   = has ? b.x : '0;
        o.corner_b_y   = has ? b.y : '0;
        o.corner_c_x   = has ? c.x : '0;
        o.corner_c_y   = has ? c.y : '0;
        o.has_triangle = has;
        o.final_result = fin;
        o.status       = st;
        return o;
    endfunction

endpackage

// ===== sv/ear_clipping_triangulator.sv =====
// ----------------------------------------------------------------------------
// ear_clipping_triangulator
// Ear-clipping triangulation of a polygon held in an on-chip vertex memory.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready, payload i_in_data): one vertex per
// transaction, one cycle each. The transaction with last_vertex set starts
// the run; o_in_ready stays low until the run's final result is handed to
// the output register.
// Output channel (o_out_valid / i_out_ready, payload o_out_data): one
// triangle per transaction; the last one has final_result set and carries
// the last triangle or only a status. Status-only results carry zero corners.
// Orientation tests run in the shared determinant unit; three-vertex fetches
// read the single-read vertex memory. One round covers the area sum, an
// optional reversal and the concave marking; the ear search then tests each
// concave vertex against each candidate tip.
// A stalled receiver holds the result register and the sequencer waits.
// Reset (synchronous, active low) empties the store and the output register.
// ----------------------------------------------------------------------------
module ear_clipping_triangulator
    import ect_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_vtx                    mem_v [MAX_VERTICES];
    logic                    mem_c [MAX_VERTICES];

    t_state                  r_state, n_state;
    t_state                  r_ret, n_ret;
    t_ssel                   r_ssel, n_ssel;
    logic [NW-1:0]           r_n, n_n;
    logic                    r_ovf, n_ovf;
    logic [NW-1:0]           r_cc, n_cc;
    logic [NW-1:0]           r_i, n_i;
    logic [NW-1:0]           r_t, n_t;
    logic [AW-1:0]           r_idx, n_idx;
    logic [AW-1:0]           r_e, n_e;
    logic [AW-1:0]           r_ni, n_ni;
    t_vtx                    r_a, n_a, r_b, n_b, r_c, n_c, r_p, n_p;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic                    r_s1p, n_s1p, r_s2p, n_s2p;
    logic                    r_s1n, n_s1n, r_s2n, n_s2n;
    t_out                    r_pend, n_pend;
    t_out                    r_out;
    logic                    r_oval;

    t_vtx                    r_vrd;
    logic                    r_crd;
    logic                    w_vwe, w_cwe, w_cwd, w_load;
    logic [AW-1:0]           w_vwa, w_vra, w_cwa, w_cra;
    t_vtx                    w_vwd;
    t_sign_req               w_req;
    logic                    w_done;
    logic signed [SUM_W-1:0] w_sval;
    logic                    w_pos, w_zero;
    logic [NW-1:0]           w_mirror;

    assign w_pos    = (w_sval > 0);
    assign w_zero   = (w_sval == '0);
    assign w_mirror = r_n - NW'(1) - r_i;
    assign w_load   = (r_state == S_EMIT) && (!r_oval || i_out_ready);

    ect_sign u_sign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_value (w_sval)
    );

    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            mem_v[w_vwa] <= w_vwd;
        end
        r_vrd <= mem_v[w_vra];
    end

    always_ff @(posedge i_clk) begin
        if (w_cwe) begin
            mem_c[w_cwa] <= w_cwd;
        end
        r_crd <= mem_c[w_cra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_n     <= n_n;
            r_ovf   <= n_ovf;
            if (w_load) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ssel <= n_ssel;
        r_cc   <= n_cc;
        r_i    <= n_i;
        r_t    <= n_t;
        r_idx  <= n_idx;
        r_e    <= n_e;
        r_ni   <= n_ni;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_p    <= n_p;
        r_acc  <= n_acc;
        r_s1p  <= n_s1p;
        r_s1n  <= n_s1n;
        r_s2p  <= n_s2p;
        r_s2n  <= n_s2n;
        r_pend <= n_pend;
        if (w_load) begin
            r_out <= r_pend;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_ssel  = r_ssel;
        n_n     = r_n;
        n_ovf   = r_ovf;
        n_cc    = r_cc;
        n_i     = r_i;
        n_t     = r_t;
        n_idx   = r_idx;
        n_e     = r_e;
        n_ni    = r_ni;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_p     = r_p;
        n_acc   = r_acc;
        n_s1p   = r_s1p;
        n_s1n   = r_s1n;
        n_s2p   = r_s2p;
        n_s2n   = r_s2n;
        n_pend  = r_pend;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_n < NW'(MAX_VERTICES)) begin
                        n_n = r_n + NW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last_vertex) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (r_ovf) begin
                    n_pend  = mk_out(r_a, r_b, r_c, 1'b0, 1'b1, ST_OVF);
                    n_ret   = S_DONE;
                    n_state = S_EMIT;
                end else if (r_n < NW'(3)) begin
                    n_pend  = mk_out(r_a, r_b, r_c, 1'b0, 1'b1, ST_FEW);
                    n_ret   = S_DONE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_n > NW'(3)) begin
                    n_state = S_AR0;
                end else if (r_n == NW'(3)) begin
                    n_idx   = AW'(1);
                    n_ret   = S_FIN;
                    n_state = S_F0;
                end else begin
                    n_pend  = mk_out(r_a, r_b, r_c, 1'b0, 1'b1, ST_OK);
                    n_ret   = S_DONE;
                    n_state = S_EMIT;
                end
            end
            S_FIN: begin
                n_pend  = mk_out(r_a, r_b, r_c, 1'b1, 1'b1, ST_OK);
                n_ret   = S_DONE;
                n_state = S_EMIT;
            end
            S_AR0: begin
                n_state = S_AR1;
            end
            S_AR1: begin
                n_p     = r_vrd;
                n_i     = NW'(1);
                n_acc   = '0;
                n_state = S_AR2;
            end
            S_AR2: begin
                if (r_i == r_n - NW'(1)) begin
                    n_state = S_ARD;
                end else begin
                    n_idx   = r_i[AW-1:0];
                    n_ret   = S_AR3;
                    n_state = S_F0;
                end
            end
            S_AR3: begin
                n_ssel  = SS_FAN;
                n_ret   = S_AR4;
                n_state = S_SG0;
            end
            S_AR4: begin
                n_acc   = r_acc + ACC_W'(w_sval);
                n_i     = r_i + NW'(1);
                n_state = S_AR2;
            end
            S_ARD: begin
                n_i = '0;
                if (!(r_acc > 0)) begin
                    n_state = S_RV0;
                end else begin
                    n_state = S_CL0;
                end
            end
            S_RV0: begin
                if (r_i >= (r_n >> 1)) begin
                    n_state = S_CL0;
                end else begin
                    n_state = S_RV1;
                end
            end
            S_RV1: begin
                n_a     = r_vrd;
                n_state = S_RV2;
            end
            S_RV2: begin
                n_state = S_RV3;
            end
            S_RV3: begin
                n_i     = r_i + NW'(1);
                n_state = S_RV0;
            end
            S_CL0: begin
                n_i     = '0;
                n_cc    = '0;
                n_state = S_CL1;
            end
            S_CL1: begin
                if (r_i == r_n) begin
                    n_state = S_ES0;
                end else begin
                    n_idx   = r_i[AW-1:0];
                    n_ret   = S_CL2;
                    n_state = S_F0;
                end
            end
            S_CL2: begin
                n_ssel  = SS_ABC;
                n_ret   = S_CL3;
                n_state = S_SG0;
            end
            S_CL3: begin
                n_cc    = r_cc + NW'(w_sval < 0);
                n_i     = r_i + NW'(1);
                n_state = S_CL1;
            end
            S_ES0: begin
                n_t     = '0;
                n_state = S_ES1;
            end
            S_ES1: begin
                if (r_t == r_n) begin
                    n_pend  = mk_out(r_a, r_b, r_c, 1'b0, 1'b1, ST_NOEAR);
                    n_ret   = S_DONE;
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_t[AW-1:0];
                    n_ret   = S_ES2;
                    n_state = S_F0;
                end
            end
            S_ES2: begin
                n_i = '0;
                if (r_cc == '0) begin
                    n_state = S_CUT0;
                end else begin
                    n_state = S_EI0;
                end
            end
            S_EI0: begin
                if (r_i + NW'(1) >= r_n) begin
                    n_state = S_CUT0;
                end else begin
                    n_state = S_EI1;
                end
            end
            S_EI1: begin
                if (!r_crd) begin
                    n_i     = r_i + NW'(1);
                    n_state = S_EI0;
                end else begin
                    n_state = S_EI2;
                end
            end
            S_EI2: begin
                n_p     = r_vrd;
                n_ssel  = SS_ABP;
                n_ret   = S_EI3;
                n_state = S_SG0;
            end
            S_EI3: begin
                n_s1p   = w_pos;
                n_s1n   = !w_pos;
                n_ssel  = SS_BCP;
                n_ret   = S_EI4;
                n_state = S_SG0;
            end
            S_EI4: begin
                n_s2p   = w_pos;
                n_s2n   = !w_pos;
                n_ssel  = SS_CAP;
                n_ret   = S_EI5;
                n_state = S_SG0;
            end
            S_EI5: begin
                if ((r_s1p && r_s2p && w_pos) || (r_s1n && r_s2n && !w_pos)) begin
                    n_t     = r_t + NW'(1);
                    n_state = S_ES1;
                end else begin
                    n_i     = r_i + NW'(1);
                    n_state = S_EI0;
                end
            end
            S_CUT0: begin
                n_ssel  = SS_ABC;
                n_ret   = S_CUT1;
                n_state = S_SG0;
            end
            S_CUT1: begin
                if (!w_zero) begin
                    n_pend  = mk_out(r_a, r_b, r_c, 1'b1, 1'b0, ST_OK);
                    n_ret   = S_CUT2;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_CUT2;
                end
            end
            S_CUT2: begin
                n_e     = r_t[AW-1:0];
                n_ret   = S_CUT3;
                n_state = S_E0;
            end
            S_CUT3: begin
                if (r_n < NW'(3)) begin
                    n_state = S_ROUND;
                end else begin
                    n_ni    = (r_t == r_n) ? '0 : r_t[AW-1:0];
                    n_idx   = (r_t == r_n) ? '0 : r_t[AW-1:0];
                    n_ret   = S_CUT4;
                    n_state = S_F0;
                end
            end
            S_CUT4: begin
                n_ssel  = SS_ABC;
                n_ret   = S_CUT5;
                n_state = S_SG0;
            end
            S_CUT5: begin
                if (w_zero) begin
                    n_e     = r_ni;
                    n_ret   = S_CUT6;
                    n_state = S_E0;
                end else begin
                    n_idx   = prev_idx(r_ni, r_n);
                    n_ret   = S_CUT8;
                    n_state = S_F0;
                end
            end
            S_CUT6: begin
                if (r_n > NW'(3)) begin
                    n_idx   = prev_idx(r_ni, r_n);
                    n_ret   = S_CUT8;
                    n_state = S_F0;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_CUT8: begin
                n_ssel  = SS_ABC;
                n_ret   = S_CUT9;
                n_state = S_SG0;
            end
            S_CUT9: begin
                if (w_zero) begin
                    n_e     = r_idx;
                    n_ret   = S_ROUND;
                    n_state = S_E0;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_F0: begin
                n_state = S_F1;
            end
            S_F1: begin
                n_a     = r_vrd;
                n_state = S_F2;
            end
            S_F2: begin
                n_b     = r_vrd;
                n_state = S_F3;
            end
            S_F3: begin
                n_c     = r_vrd;
                n_state = r_ret;
            end
            S_SG0: begin
                n_state = S_SG1;
            end
            S_SG1: begin
                if (w_done) begin
                    n_state = r_ret;
                end
            end
            S_E0: begin
                if (NW'(r_e) + NW'(1) >= r_n) begin
                    n_n     = r_n - NW'(1);
                    n_state = r_ret;
                end else begin
                    n_state = S_E1;
                end
            end
            S_E1: begin
                n_e     = r_e + AW'(1);
                n_state = S_E0;
            end
            S_EMIT: begin
                if (!r_oval || i_out_ready) begin
                    n_state = r_ret;
                end
            end
            S_DONE: begin
                n_n     = '0;
                n_ovf   = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_vwe       = 1'b0;
        w_vwa       = r_e;
        w_vwd       = r_vrd;
        w_vra       = r_idx;
        w_cwe       = 1'b0;
        w_cwa       = r_i[AW-1:0];
        w_cwd       = (w_sval < 0);
        w_cra       = r_i[AW-1:0];
        w_req.start = 1'b0;
        w_req.a     = r_a;
        w_req.b     = r_b;
        w_req.c     = r_c;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                w_vwe         = i_in_valid && (r_n < NW'(MAX_VERTICES));
                w_vwa         = r_n[AW-1:0];
                w_vwd.x       = i_in_data.vertex_x;
                w_vwd.y       = i_in_data.vertex_y;
            end
            S_AR0: begin
                w_vra = '0;
            end
            S_RV0: begin
                w_vra = r_i[AW-1:0];
            end
            S_RV1: begin
                w_vra = w_mirror[AW-1:0];
            end
            S_RV2: begin
                w_vwe = 1'b1;
                w_vwa = r_i[AW-1:0];
                w_vwd = r_vrd;
            end
            S_RV3: begin
                w_vwe = 1'b1;
                w_vwa = w_mirror[AW-1:0];
                w_vwd = r_a;
            end
            S_CL3: begin
                w_cwe = 1'b1;
            end
            S_EI0: begin
                w_cra = r_i[AW-1:0];
            end
            S_EI1: begin
                w_vra = r_i[AW-1:0];
            end
            S_F0: begin
                w_vra = prev_idx(r_idx, r_n);
            end
            S_F1: begin
                w_vra = r_idx;
            end
            S_F2: begin
                w_vra = next_idx(r_idx, r_n);
            end
            S_SG0: begin
                w_req.start = 1'b1;
                case (r_ssel)
                    SS_ABP: begin
                        w_req.c = r_p;
                    end
                    SS_BCP: begin
                        w_req.a = r_b;
                        w_req.b = r_c;
                        w_req.c = r_p;
                    end
                    SS_CAP: begin
                        w_req.a = r_c;
                        w_req.b = r_a;
                        w_req.c = r_p;
                    end
                    SS_FAN: begin
                        w_req.a = r_p;
                    end
                    default: begin
                    end
                endcase
            end
            S_E0: begin
                w_vra = r_e + AW'(1);
            end
            S_E1: begin
                w_vwe = 1'b1;
                w_vwa = r_e;
                w_vwd = r_vrd;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

endmodule

// ===== sv/ect_sign.sv =====
// ----------------------------------------------------------------------------
// ect_sign
// Multi-cycle orientation determinant of three vertices, one product a cycle.
// ----------------------------------------------------------------------------
module ect_sign
    import ect_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_sign_req               i_req,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_value
);

    logic signed [COORD_BITS-1:0]   r_x [3];
    logic signed [COORD_BITS:0]     r_d [3];
    logic signed [2*COORD_BITS:0]   r_prod;
    logic signed [SUM_W-1:0]        r_acc;
    logic                           r_busy;
    logic                           r_pv;
    logic                           r_done;
    logic [1:0]                     r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_k    <= 2'd0;
            end else if (r_busy) begin
                if (r_k != 2'd3) begin
                    r_k  <= r_k + 2'd1;
                    r_pv <= 1'b1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_k == 2'd3 && r_pv) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x[0] <= i_req.a.x;
            r_x[1] <= i_req.b.x;
            r_x[2] <= i_req.c.x;
            r_d[0] <= (COORD_BITS+1)'(i_req.c.y) - (COORD_BITS+1)'(i_req.b.y);
            r_d[1] <= (COORD_BITS+1)'(i_req.a.y) - (COORD_BITS+1)'(i_req.c.y);
            r_d[2] <= (COORD_BITS+1)'(i_req.b.y) - (COORD_BITS+1)'(i_req.a.y);
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_k != 2'd3) begin
                r_prod <= r_x[r_k] * r_d[r_k];
            end
            if (r_pv) begin
                r_acc <= r_acc + SUM_W'(r_prod);
            end
        end
    end

    assign o_done  = r_done;
    assign o_value = r_acc;

endmodule

// ===== sv/ect_checker.sv =====
// ----------------------------------------------------------------------------
// ect_checker
// Port-level checks of the triangulator's result channel.
// ----------------------------------------------------------------------------
module ect_checker
    import ect_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_triangle |->
            o_out_data.corner_a_x == '0 && o_out_data.corner_a_y == '0 &&
            o_out_data.corner_b_x == '0 && o_out_data.corner_b_y == '0 &&
            o_out_data.corner_c_x == '0 && o_out_data.corner_c_y == '0)
        else $error("status result with corners");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.final_result && !o_out_data.has_triangle)
        else $error("error status not final");

    a_nonfinal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.final_result |-> o_out_data.has_triangle)
        else $error("non-final result without triangle");

endmodule

bind ear_clipping_triangulator ect_checker u_ect_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
